### rtl/firfp_pkg.sv
package firfp_pkg;

    localparam int VALUE_W = 16;
    localparam int IDX_W   = 8;
    localparam int TAPS_W  = 9;
    localparam int OUT_W   = 40;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    localparam logic [TAPS_W-1:0] TAPS_RESET = TAPS_W'(1);

    typedef struct packed {
        logic              shift;
        logic              coef_wr;
        logic [IDX_W-1:0]  coef_idx;
        logic [TAPS_W-1:0] taps;
        logic              advance;
    } cell_ctrl_t;

endpackage

### rtl/firfp_cell.sv
module firfp_cell
    import firfp_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_W       = 40,
    parameter int TAP_INDEX   = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [SAMPLE_BITS-1:0] load_value,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    input  logic                          token_in,
    input  logic signed [ACC_W-1:0]       sum_in,
    output logic                          token_out,
    output logic signed [ACC_W-1:0]       sum_out
);

    localparam int PROD_W = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic signed [SAMPLE_BITS-1:0] coef_reg, coef_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic                          token_reg, token_next;
    logic signed [ACC_W-1:0]       sum_reg, sum_next;
    logic                          tap_en;
    logic                          coef_hit;

    assign tap_en   = int'(ctrl.taps) > TAP_INDEX;
    assign coef_hit = ctrl.coef_wr && (int'(ctrl.coef_idx) == TAP_INDEX);

    always_comb begin
        sample_next = ctrl.shift ? sample_in : sample_reg;
        coef_next   = coef_hit ? load_value : coef_reg;
        prod_next   = sample_reg * coef_reg;
        token_next  = ctrl.advance ? token_in : token_reg;
        sum_next    = sum_reg;
        if (ctrl.advance && token_in) begin
            sum_next = tap_en ? sum_in + ACC_W'(prod_reg) : sum_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            coef_reg   <= '0;
            token_reg  <= 1'b0;
        end else begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
            token_reg  <= token_next;
        end
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign sample_out = sample_reg;
    assign token_out  = token_reg;
    assign sum_out    = sum_reg;

endmodule

### rtl/fir_filter_fixed_point.sv
// Sample beat: the token passes start_reg and launch_reg, then the partial sum
// ripples through the tap cells one cell per cycle while the output is not stalled.
// After a sample beat no further beat is accepted until its result is loaded for
// m_valid; a coefficient beat does not hold off the next beat.
// Reset (aresetn low, synchronous): delay line and coefficients cleared,
// active_taps set to 1, no result pending.
module fir_filter_fixed_point
    import firfp_pkg::*;
#(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [TAPS_W-1:0]         cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [IDX_W-1:0]          s_tap_index,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_filtered_out
);

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int SUM_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;
    localparam int EXT_W  = (SAMPLE_BITS > VALUE_W) ? SAMPLE_BITS : VALUE_W;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        SUM_W'($signed({1'b0, {(OUT_W-1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        SUM_W'($signed({1'b1, {(OUT_W-1){1'b0}}}));

    logic [TAPS_W-1:0]       active_taps_reg, active_taps_next;
    logic                    busy_reg, busy_next;
    logic                    start_reg, start_next;
    logic                    launch_reg, launch_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0] m_data_reg, m_data_next;

    logic                          s_accept;
    logic                          sample_beat;
    logic [EXT_W-1:0]              value_ext;
    logic signed [SAMPLE_BITS-1:0] new_sample;
    logic                          out_load;
    cell_ctrl_t                    ctrl;
    logic signed [SUM_W-1:0]       sum_ext;
    logic signed [OUT_W-1:0]       sat_sum;

    logic                          tok [0:MAX_TAPS];
    logic signed [ACC_W-1:0]       sum [0:MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] smp [0:MAX_TAPS-1];

    assign s_ready     = !busy_reg;
    assign s_accept    = s_valid && s_ready;
    assign sample_beat = s_accept && (s_req_type == REQ_SAMPLE);
    assign value_ext   = EXT_W'($unsigned(s_value));
    assign new_sample  = $signed(value_ext[SAMPLE_BITS-1:0]);

    assign out_load = tok[MAX_TAPS] && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.shift    = sample_beat;
        ctrl.coef_wr  = s_accept && (s_req_type == REQ_COEF);
        ctrl.coef_idx = s_tap_index;
        ctrl.taps     = active_taps_reg;
        ctrl.advance  = !tok[MAX_TAPS] || out_load;
    end

    assign tok[0] = launch_reg;
    assign sum[0] = '0;
    assign smp[0] = new_sample;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
        if (k < MAX_TAPS - 1) begin : g_mid
            firfp_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .ACC_W      (ACC_W),
                .TAP_INDEX  (k)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .load_value(new_sample),
                .sample_in (smp[k]),
                .sample_out(smp[k+1]),
                .token_in  (tok[k]),
                .sum_in    (sum[k]),
                .token_out (tok[k+1]),
                .sum_out   (sum[k+1])
            );
        end else begin : g_last
            firfp_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .ACC_W      (ACC_W),
                .TAP_INDEX  (k)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .load_value(new_sample),
                .sample_in (smp[k]),
                .sample_out(),
                .token_in  (tok[k]),
                .sum_in    (sum[k]),
                .token_out (tok[k+1]),
                .sum_out   (sum[k+1])
            );
        end
    end

    // clamp to the 40-bit result range
    always_comb begin
        sum_ext = SUM_W'(sum[MAX_TAPS]);
        priority if (sum_ext > SAT_MAX) begin
            sat_sum = SAT_MAX[OUT_W-1:0];
        end else if (sum_ext < SAT_MIN) begin
            sat_sum = SAT_MIN[OUT_W-1:0];
        end else begin
            sat_sum = sum_ext[OUT_W-1:0];
        end
    end

    always_comb begin
        active_taps_next = cfg_wr_en ? cfg_wr_data : active_taps_reg;
        start_next       = sample_beat;
        launch_next      = start_reg;
        busy_next        = busy_reg;
        if (sample_beat) begin
            busy_next = 1'b1;
        end else if (out_load) begin
            busy_next = 1'b0;
        end
        m_data_next  = out_load ? sat_sum : m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_taps_reg <= TAPS_RESET;
            busy_reg        <= 1'b0;
            start_reg       <= 1'b0;
            launch_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            active_taps_reg <= active_taps_next;
            busy_reg        <= busy_next;
            start_reg       <= start_next;
            launch_reg      <= launch_next;
            m_valid_reg     <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_filtered_out = m_data_reg;

endmodule

### sim/tb_top.sv
module tb_top
    import firfp_pkg::*;
();

    localparam int MAX_TAPS = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int BEAT_TARGET = 1600;
    localparam int CALM_AFTER = 1400;
    localparam longint SUM_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic                      req;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] val;
        bit                        typed;
        logic signed [OUT_W-1:0]   sum;
        logic [TAPS_W-1:0]         taps;
    } plan_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [TAPS_W-1:0]         cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_req_type = REQ_SAMPLE;
    logic [IDX_W-1:0]          s_tap_index = '0;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [OUT_W-1:0]   m_filtered_out;

    logic signed [VALUE_W-1:0] coef_bank [MAX_TAPS];
    logic signed [VALUE_W-1:0] sample_hist [MAX_TAPS];
    logic [TAPS_W-1:0]         taps_now = TAPS_RESET;
    logic signed [OUT_W-1:0]   expected_sums [$];
    logic signed [OUT_W-1:0]   want_sum;
    plan_row_t                 plan [$];

    bit calm = 1'b0;
    int ready_run = 0;
    int fail_count = 0;
    int sums_checked = 0;
    int beats_sent = 0;
    int coef_beats = 0;
    int sample_beats = 0;
    int tap_settings = 0;

    fir_filter_fixed_point #(
        .MAX_TAPS(MAX_TAPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_tap_index(s_tap_index),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_filtered_out(m_filtered_out)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Timed out after %0d cycles", CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // shift in the new sample, then sum coefficient times history over active taps and clamp to the result range
    function automatic logic signed [OUT_W-1:0] next_fir_sum(
        input logic signed [VALUE_W-1:0] smp);
        longint acc;
        int n;
        acc = 0;
        for (int k = MAX_TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
        sample_hist[0] = smp;
        n = (taps_now > MAX_TAPS) ? MAX_TAPS : int'(taps_now);
        for (int k = 0; k < n; k++)
            acc += longint'(coef_bank[k]) * longint'(sample_hist[k]);
        if (acc > SUM_MAX) acc = SUM_MAX;
        if (acc < SUM_MIN) acc = SUM_MIN;
        return acc[OUT_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_q15();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [TAPS_W-1:0] rand_taps();
        case ($urandom_range(0, 7))
            0: return TAPS_W'(0);
            1: return TAPS_W'(1);
            2: return TAPS_W'(MAX_TAPS);
            3: return TAPS_W'(511);
            4: return TAPS_W'($urandom_range(MAX_TAPS + 1, 511));
            5, 6: return TAPS_W'($urandom_range(2, 16));
            default: return TAPS_W'($urandom_range(0, 511));
        endcase
    endfunction

    task automatic plan_beat(input logic req, input int idx, input int val,
                             input bit typed = 1'b0, input longint sum = 0);
        plan_row_t r;
        r.kind = ROW_BEAT;
        r.req = req;
        r.idx = idx[IDX_W-1:0];
        r.val = val[VALUE_W-1:0];
        r.typed = typed;
        r.sum = sum[OUT_W-1:0];
        r.taps = '0;
        plan.push_back(r);
    endtask

    task automatic plan_cfg(input int taps);
        plan_row_t r;
        r.kind = ROW_CFG;
        r.req = REQ_SAMPLE;
        r.idx = '0;
        r.val = '0;
        r.typed = 1'b0;
        r.sum = '0;
        r.taps = taps[TAPS_W-1:0];
        plan.push_back(r);
    endtask

    task automatic pause_sender(input int n);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_beat(input logic req, input logic [IDX_W-1:0] idx,
                             input logic signed [VALUE_W-1:0] val,
                             input bit typed = 1'b0,
                             input logic signed [OUT_W-1:0] typed_sum = '0);
        logic signed [OUT_W-1:0] sum;
        if (!calm && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 19));
        @(negedge aclk);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_tap_index <= idx;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (req == REQ_COEF) begin
            coef_bank[idx] = val;
            coef_beats++;
        end else begin
            sum = next_fir_sum(val);
            expected_sums.push_back(typed ? typed_sum : sum);
            sample_beats++;
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(negedge aclk);
    endtask

    // coefficient beats give no result, so let the pipeline empty before writing
    task automatic set_taps(input logic [TAPS_W-1:0] v);
        drain();
        repeat (MAX_TAPS + 3) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        taps_now = v;
        tap_settings++;
    endtask

    task automatic note_mismatch(input string what, input logic signed [OUT_W-1:0] want,
                                 input logic signed [OUT_W-1:0] got);
        if (fail_count < 10)
            $display("Mismatch (%s) at cycle time %0t: expected %0d, got %0d",
                     what, $time, want, got);
        fail_count++;
    endtask

    always @(negedge aclk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else if (!calm && m_ready && $urandom_range(0, 1) == 0) begin
            m_ready <= 1'b0;
            ready_run = $urandom_range(1, 19);
        end else begin
            m_ready <= 1'b1;
            ready_run = calm ? 0 : $urandom_range(1, 40);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                note_mismatch("no result pending", '0, m_filtered_out);
            end else begin
                want_sum = expected_sums.pop_front();
                if (m_filtered_out !== want_sum)
                    note_mismatch("filtered_out", want_sum, m_filtered_out);
                sums_checked++;
            end
        end
    end

    initial begin
        logic [TAPS_W-1:0] pick;
        int n;
        int span;
        int idx;

        for (int k = 0; k < MAX_TAPS; k++) begin
            coef_bank[k] = '0;
            sample_hist[k] = '0;
        end

        // directed: reset state, extremes, zero taps, tap count above the line length
        plan_beat(REQ_SAMPLE, 8'hAB, 32767, 1'b1, 0);
        plan_beat(REQ_COEF, 0, -32768);
        plan_beat(REQ_SAMPLE, 0, -32768, 1'b1, 64'sd1073741824);
        plan_beat(REQ_SAMPLE, 0, 32767, 1'b1, -64'sd1073709056);
        plan_beat(REQ_COEF, 1, 32767);
        plan_beat(REQ_COEF, 255, -32768);
        plan_beat(REQ_COEF, 2, 16'h5555);
        plan_cfg(0);
        plan_beat(REQ_SAMPLE, 0, 1234, 1'b1, 0);
        plan_beat(REQ_SAMPLE, 0, -1, 1'b1, 0);
        plan_cfg(3);
        plan_beat(REQ_SAMPLE, 0, 0);
        plan_beat(REQ_COEF, 128, 16'hAAAA);
        plan_cfg(256);
        plan_beat(REQ_SAMPLE, 8'hFF, 32767);
        plan_cfg(511);
        plan_beat(REQ_SAMPLE, 0, -32768);
        plan_beat(REQ_COEF, 0, 0);
        plan_cfg(2);
        plan_beat(REQ_SAMPLE, 0, 1);
        plan_cfg(255);
        plan_beat(REQ_SAMPLE, 0, 100);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                set_taps(plan[i].taps);
            else
                send_beat(plan[i].req, plan[i].idx, plan[i].val, plan[i].typed, plan[i].sum);
        end

        // full-scale fill: largest positive sum, then swing to the most negative
        set_taps(TAPS_W'(MAX_TAPS));
        for (int k = 0; k < MAX_TAPS; k++)
            send_beat(REQ_COEF, IDX_W'(k), 16'sh8000);
        repeat (MAX_TAPS) send_beat(REQ_SAMPLE, '0, 16'sh8000);
        repeat (MAX_TAPS) send_beat(REQ_SAMPLE, '0, 16'sh7FFF);

        while (beats_sent < BEAT_TARGET) begin
            pick = rand_taps();
            set_taps(pick);
            calm = (beats_sent >= CALM_AFTER);
            n = $urandom_range(15, 60);
            span = (pick == 0) ? MAX_TAPS : ((pick > MAX_TAPS) ? MAX_TAPS : int'(pick));
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) begin
                    idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_TAPS - 1)
                                                      : $urandom_range(0, span - 1);
                    send_beat(REQ_COEF, IDX_W'(idx), rand_q15());
                end else begin
                    send_beat(REQ_SAMPLE, IDX_W'($urandom), rand_q15());
                end
            end
        end

        drain();
        repeat (MAX_TAPS + 8) @(posedge aclk);

        $display("Ran %0d coefficient loads and %0d samples over %0d tap-count settings",
                 coef_beats, sample_beats, tap_settings);
        $display("Compared %0d filter sums, %0d failures, %0d still owed",
                 sums_checked, fail_count, expected_sums.size());
        if (fail_count == 0 && expected_sums.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
